// File: rtl/htbc_pkg.sv
package htbc_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int POS_W   = 11;
    localparam int SUM_W   = 34;
    localparam int TALLY_W = 23;
    localparam int FW_W    = 12;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int HSV_DIV_STAGES = 8;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [2:0] REG_LOWER_HUE   = 3'd1;
    localparam logic [2:0] REG_UPPER_HUE   = 3'd2;
    localparam logic [2:0] REG_LOWER_SAT   = 3'd3;
    localparam logic [2:0] REG_UPPER_SAT   = 3'd4;
    localparam logic [2:0] REG_LOWER_VAL   = 3'd5;
    localparam logic [2:0] REG_UPPER_VAL   = 3'd6;

    typedef struct packed {
        logic start_div;
        logic load_result;
    } htbc_cmd_t;

    typedef struct packed {
        logic div_done;
    } htbc_status_t;
endpackage

// File: rtl/htbc_divider.sv
module htbc_divider
    import htbc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   numer,
    input  logic [TALLY_W-1:0] denom,
    output logic [SUM_W-1:0]   quot,
    output logic               done
);
    logic [SUM_W-1:0]     q_reg, q_next;
    logic [TALLY_W:0]     r_reg, r_next;
    logic [TALLY_W-1:0]   d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [TALLY_W:0]     trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[TALLY_W-1:0], q_reg[SUM_W-1]};
        if (start) begin
            q_next = numer; r_next = '0;
            cnt_next = DIV_CNT_W'(SUM_W); busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[SUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; cnt_reg <= cnt_next;
        if (start) d_reg <= denom;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end
    assign quot = q_reg;
    assign done = done_reg;
endmodule

// File: rtl/htbc_datapath.sv
module htbc_datapath
    import htbc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [FW_W-1:0]    cfg_data,
    input  logic               pix_fire,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  logic               eof,
    input  htbc_cmd_t          cmd,
    output htbc_status_t       status,
    output logic               eof_out,
    output logic               res_zero,
    output logic [POS_W-1:0]   res_col,
    output logic [POS_W-1:0]   res_row,
    output logic               res_found,
    output logic [TALLY_W-1:0] res_count
);
    logic [FW_W-1:0] fw_reg;
    logic [7:0] lh_reg, uh_reg, ls_reg, us_reg, lv_reg, uv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 12'd640; lh_reg <= 8'd110; uh_reg <= 8'd130;
            ls_reg <= 8'd150; us_reg <= 8'd255; lv_reg <= 8'd150; uv_reg <= 8'd255;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH: fw_reg <= cfg_data;
                REG_LOWER_HUE:   lh_reg <= cfg_data[7:0];
                REG_UPPER_HUE:   uh_reg <= cfg_data[7:0];
                REG_LOWER_SAT:   ls_reg <= cfg_data[7:0];
                REG_UPPER_SAT:   us_reg <= cfg_data[7:0];
                REG_LOWER_VAL:   lv_reg <= cfg_data[7:0];
                REG_UPPER_VAL:   uv_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage 1: max/min and hue numerator
    logic [7:0] mx, mn, diff;
    logic [10:0] x;
    always_comb begin
        logic [10:0] xs;
        mx = red; mn = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        diff = mx - mn;
        if (mx == red)        xs = {3'b0, green} - {3'b0, blue};
        else if (mx == green) xs = {3'b0, blue} - {3'b0, red} + {2'b0, diff, 1'b0};
        else                  xs = {3'b0, red} - {3'b0, green} + {1'b0, diff, 2'b0};
        if (xs[10]) xs = xs + 11'(6 * diff);
        x = xs;
    end

    logic        s1_v_reg, s1_eof_reg;
    logic [7:0]  s1_mx_reg, s1_diff_reg;
    logic [10:0] s1_x_reg;
    always_ff @(posedge aclk) begin
        s1_mx_reg <= mx; s1_diff_reg <= diff; s1_x_reg <= x; s1_eof_reg <= eof;
        if (!aresetn) s1_v_reg <= 1'b0; else s1_v_reg <= pix_fire;
    end

    // hue and saturation divides: restoring, 8 quotient bits, over 8 stages
    logic [HSV_DIV_STAGES:0] p_v, p_eof;
    logic [7:0]        p_mx   [HSV_DIV_STAGES+1];
    logic [17:0]       p_hn   [HSV_DIV_STAGES+1];
    logic [8:0]        p_hd   [HSV_DIV_STAGES+1];
    logic [17:0]       p_sn   [HSV_DIV_STAGES+1];
    logic [8:0]        p_sd   [HSV_DIV_STAGES+1];
    logic [7:0]        p_hq   [HSV_DIV_STAGES+1];
    logic [7:0]        p_sq   [HSV_DIV_STAGES+1];
    logic [HSV_DIV_STAGES:0] p_hz;

    assign p_v[0] = s1_v_reg;
    assign p_eof[0] = s1_eof_reg;
    assign p_mx[0] = s1_mx_reg;
    assign p_hn[0] = 18'(18'(60) * s1_x_reg) + 18'(s1_diff_reg);
    assign p_hd[0] = {s1_diff_reg, 1'b0};
    assign p_sn[0] = 18'(17'(510) * s1_diff_reg) + 18'(s1_mx_reg);
    assign p_sd[0] = {s1_mx_reg, 1'b0};
    assign p_hq[0] = '0;
    assign p_sq[0] = '0;
    assign p_hz[0] = (s1_diff_reg == 8'd0);

    for (genvar i = 0; i < HSV_DIV_STAGES; i++) begin : g_div
        logic [17:0] hn_n, sn_n;
        logic        hb, sb;
        always_comb begin
            hb = p_hn[i] >= (18'(p_hd[i]) << (HSV_DIV_STAGES - 1 - i));
            sb = p_sn[i] >= (18'(p_sd[i]) << (HSV_DIV_STAGES - 1 - i));
            hn_n = hb ? p_hn[i] - (18'(p_hd[i]) << (HSV_DIV_STAGES - 1 - i)) : p_hn[i];
            sn_n = sb ? p_sn[i] - (18'(p_sd[i]) << (HSV_DIV_STAGES - 1 - i)) : p_sn[i];
        end
        always_ff @(posedge aclk) begin
            p_mx[i+1] <= p_mx[i]; p_hd[i+1] <= p_hd[i]; p_sd[i+1] <= p_sd[i];
            p_hn[i+1] <= hn_n; p_sn[i+1] <= sn_n;
            p_hq[i+1] <= {p_hq[i][6:0], hb}; p_sq[i+1] <= {p_sq[i][6:0], sb};
            p_hz[i+1] <= p_hz[i]; p_eof[i+1] <= p_eof[i];
            if (!aresetn) p_v[i+1] <= 1'b0; else p_v[i+1] <= p_v[i];
        end
    end

    logic [7:0] hue, sat, val;
    logic       match;
    always_comb begin
        hue = p_hz[HSV_DIV_STAGES] ? 8'd0 : p_hq[HSV_DIV_STAGES];
        if (hue >= 8'd180) hue = hue - 8'd180;
        sat = (p_mx[HSV_DIV_STAGES] == 8'd0) ? 8'd0 : p_sq[HSV_DIV_STAGES];
        val = p_mx[HSV_DIV_STAGES];
        match = hue >= lh_reg && hue <= uh_reg && sat >= ls_reg && sat <= us_reg &&
                val >= lv_reg && val <= uv_reg;
    end

    // accumulation
    logic [POS_W-1:0]   col_reg, row_reg, col_next, row_next;
    logic [SUM_W-1:0]   csum_reg, rsum_reg, csum_next, rsum_next;
    logic [TALLY_W-1:0] tally_reg, tally_next, cnt_reg;
    logic [FW_W-1:0]    width;
    logic               eofo_reg, found_reg;
    logic [POS_W-1:0]   lcol_reg, lrow_reg;
    logic [SUM_W-1:0]   cq, rq;
    logic               cdone, rdone;

    always_comb begin
        width = fw_reg;
        if (width > FW_W'(MAX_WIDTH)) width = FW_W'(MAX_WIDTH);
        if (width == '0) width = FW_W'(1);
        col_next = col_reg; row_next = row_reg;
        csum_next = csum_reg; rsum_next = rsum_reg; tally_next = tally_reg;
        if (p_v[HSV_DIV_STAGES]) begin
            if (match && tally_reg != TALLY_MAX) begin
                tally_next = tally_reg + 1'b1;
                csum_next = csum_reg + SUM_W'(col_reg);
                rsum_next = rsum_reg + SUM_W'(row_reg);
            end
            if ({1'b0, col_reg} + 12'd1 >= width) begin
                col_next = '0;
                if ({1'b0, row_reg} + 12'd1 < 12'(MAX_HEIGHT)) row_next = row_reg + 1'b1;
            end else col_next = col_reg + 1'b1;
            if (p_eof[HSV_DIV_STAGES]) begin
                col_next = '0; row_next = '0; csum_next = '0; rsum_next = '0;
                tally_next = '0;
            end
        end
    end

    logic [SUM_W-1:0] dcs_reg, drs_reg;
    always_ff @(posedge aclk) begin
        if (p_v[HSV_DIV_STAGES] && p_eof[HSV_DIV_STAGES]) begin
            dcs_reg <= csum_reg + ((match && tally_reg != TALLY_MAX) ? SUM_W'(col_reg) : '0);
            drs_reg <= rsum_reg + ((match && tally_reg != TALLY_MAX) ? SUM_W'(row_reg) : '0);
            cnt_reg <= tally_reg + TALLY_W'(match && tally_reg != TALLY_MAX);
        end
        if (!aresetn) begin
            col_reg <= '0; row_reg <= '0; csum_reg <= '0; rsum_reg <= '0; tally_reg <= '0;
            eofo_reg <= 1'b0; lcol_reg <= '0; lrow_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            col_reg <= col_next; row_reg <= row_next; csum_reg <= csum_next;
            rsum_reg <= rsum_next; tally_reg <= tally_next;
            eofo_reg <= p_v[HSV_DIV_STAGES] && p_eof[HSV_DIV_STAGES];
            if (cmd.load_result) begin
                found_reg <= (cnt_reg != '0);
                if (cnt_reg != '0) begin
                    lcol_reg <= cq[POS_W-1:0]; lrow_reg <= rq[POS_W-1:0];
                end
            end
        end
    end

    htbc_divider u_cdiv (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start_div),
        .numer(dcs_reg), .denom(cnt_reg), .quot(cq), .done(cdone));
    htbc_divider u_rdiv (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.start_div),
        .numer(drs_reg), .denom(cnt_reg), .quot(rq), .done(rdone));

    assign status.div_done = cdone & rdone;
    assign eof_out   = eofo_reg;
    assign res_zero  = (cnt_reg == '0);
    assign res_col   = lcol_reg;
    assign res_row   = lrow_reg;
    assign res_found = found_reg;
    assign res_count = cnt_reg;
endmodule

// File: rtl/htbc_ctrl.sv
module htbc_ctrl
    import htbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         eof_in,
    input  logic         pipe_eof,
    input  logic         res_zero,
    input  htbc_status_t status,
    input  logic         m_ready,
    output htbc_cmd_t    cmd,
    output logic         in_ready,
    output logic         m_valid
);
    typedef enum logic [4:0] {
        ST_RUN   = 5'b00001,
        ST_DRAIN = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;
    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_RUN:   if (eof_in) state_next = ST_DRAIN;
            ST_DRAIN: if (pipe_eof) begin
                if (res_zero) state_next = ST_LOAD;
                else begin cmd.start_div = 1'b1; state_next = ST_DIV; end
            end
            ST_DIV:   if (status.div_done) state_next = ST_LOAD;
            ST_LOAD:  begin cmd.load_result = 1'b1; state_next = ST_OUT; end
            ST_OUT:   if (m_ready) state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_RUN);
    assign m_valid  = (state_reg == ST_OUT);
endmodule

// File: rtl/hsv_threshold_blob_centroid_top.sv
// HSV colour threshold and blob centroid.
// s_axis: one BGR pixel per transaction; tlast marks the last pixel of a frame.
// m_axis: one centroid result per frame, sent after the last pixel.
// cfg: cfg_we/cfg_index/cfg_data write the seven threshold and width registers.
// Pixels are taken at one per cycle through a nine-stage colour pipeline
// (max/min, then eight stages of restoring division for hue and saturation).
// At end of frame input stalls until the result leaves: the pipeline drains,
// the bit-serial divides for column and row means run (skipped when no
// pixel matched), and the load state fills the output register before
// m_axis_tvalid rises. The result then waits in the output register for
// m_axis_tready. A receiver stall holds the result and keeps s_axis_tready
// low; input resumes the cycle after the result transaction. Reset restores
// register defaults and clears position, sums, tally and the last centroid.
module hsv_threshold_blob_centroid_top
    import htbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue, green, red
    input  logic        s_axis_tlast,   // end_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // centroid_column, centroid_row, found, match_count
);
    htbc_cmd_t    cmd;
    htbc_status_t status;
    logic eof_out, res_zero, res_found, fire, ready;
    logic [POS_W-1:0] res_col, res_row;
    logic [TALLY_W-1:0] res_count;

    assign fire = s_axis_tvalid & ready;
    assign s_axis_tready = ready;

    htbc_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix_fire(fire), .blue(s_axis_tdata[7:0]),
        .green(s_axis_tdata[15:8]), .red(s_axis_tdata[23:16]), .eof(s_axis_tlast),
        .cmd(cmd), .status(status), .eof_out(eof_out), .res_zero(res_zero),
        .res_col(res_col), .res_row(res_row), .res_found(res_found),
        .res_count(res_count));

    htbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .eof_in(fire & s_axis_tlast),
        .pipe_eof(eof_out), .res_zero(res_zero), .status(status),
        .m_ready(m_axis_tready), .cmd(cmd), .in_ready(ready), .m_valid(m_axis_tvalid));

    assign m_axis_tdata = {2'b0, res_count, res_found, res_row, res_col};
endmodule
